// ===== hw/rtl/tspc_pkg.sv =====
// Shared types, constants and the CRC-8 step for the temperature sensor poll block.
// No dependencies; every other file refers to this package by scoped names.
package tspc_pkg;

  localparam logic [15:0] REFRESH_RESET = 16'd5000;
  localparam logic [15:0] CONV_RESET    = 16'd1000;
  localparam logic [16:0] SCALE_UC      = 17'd62500;
  localparam logic [7:0]  CRC_POLY      = 8'h8C;
  localparam logic [3:0]  CRC_BYTES     = 4'd8;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_BYTE   = 2'd1,
    OP_NOPRES = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CMD_NONE    = 2'd0,
    CMD_CONVERT = 2'd1,
    CMD_READ    = 2'd2
  } cmd_t;

  typedef enum logic {
    REG_REFRESH = 1'b0,
    REG_CONV    = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] refresh_ivl;
    logic [15:0] conv_ms;
  } cfg_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] now_ms;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    cmd_t               bus_command;
    logic               busy_res;
    logic               reading_valid;
    logic signed [31:0] temp_micro_c;
  } res_t;

  // One byte through the reflected CRC-8, LSB first.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/temp_sensor_poll_crc8_check.sv =====
// Top level of the temperature sensor poll scheduler with scratchpad CRC-8 check.
// Depends on tspc_pkg, tspc_cfg_regs and tspc_core.
//
// Usage:
//   in_*   : stream of items. in_tuser[1:0] is the opcode (tick, scratchpad
//            byte, no presence pulse); in_tdata carries now_ms and data_byte.
//   out_*  : one result item per input item, in order: bus command to issue,
//            busy flag, reading-valid flag and temperature in micro-degrees C.
//   cfg_*  : APB-style port; refresh interval at 0x0, conversion time at 0x4,
//            both 16 bits. Write only while the stream is idle.
// Timing:
//   An accepted item lands in the input register, is processed by the
//   single-pass core as it moves to the result register, and shows on
//   out_* from there. One item per cycle sustained while out_tready is
//   high; the state update and the 16 x 17 constant multiply fit in the one core stage.
// Reset (rst_n low, synchronous): both pipeline registers empty, all poll
//   and CRC state cleared, registers back to 5000 ms and 1000 ms.
// Stall: when out_tready is low the result register holds, the input
//   register holds its item, and in_tready drops once both are full.
module temp_sensor_poll_crc8_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] now_ms, [39:32] data_byte
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [1:0] bus_command, [2] busy_res,
                                  // [3] reading_valid, [35:4] temp_micro_c, [39:36] zero
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  tspc_pkg::cfg_t  cfg;
  tspc_pkg::item_t in_item_r;
  tspc_pkg::res_t  res;
  tspc_pkg::res_t  out_res_r;
  logic            in_v_r;
  logic            out_v_r;
  logic            adv;
  logic            in_acc;

  tspc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Advance the held item into the result register when that slot is free
  // or being emptied this cycle.
  assign adv       = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  tspc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (in_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  // Input register: control bit reset, payload loads on accept only.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_acc) begin
      in_v_r <= 1'b1;
    end else if (adv) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_item_r.op        <= tspc_pkg::op_t'(in_tuser);
      in_item_r.now_ms    <= in_tdata[31:0];
      in_item_r.data_byte <= in_tdata[39:32];
    end
  end

  // Result register: hold while the receiver stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'd0, out_res_r.temp_micro_c, out_res_r.reading_valid,
                       out_res_r.busy_res, out_res_r.bus_command};

endmodule

// ===== hw/rtl/tspc_cfg_regs.sv =====
// APB-style configuration registers: refresh interval and conversion time.
// Depends on tspc_pkg for the register index codes and the cfg_t bundle.
module tspc_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output tspc_pkg::cfg_t    cfg
);

  logic [15:0] refresh_r;
  logic [15:0] conv_r;
  logic        wr_en;
  tspc_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = tspc_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      refresh_r <= tspc_pkg::REFRESH_RESET;
      conv_r    <= tspc_pkg::CONV_RESET;
    end else if (wr_en) begin
      case (idx)
        tspc_pkg::REG_REFRESH: refresh_r <= pwdata[15:0];
        tspc_pkg::REG_CONV:    conv_r    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      tspc_pkg::REG_REFRESH: prdata = {16'd0, refresh_r};
      tspc_pkg::REG_CONV:    prdata = {16'd0, conv_r};
      default:               prdata = 32'd0;
    endcase
  end

  assign cfg.refresh_ivl = refresh_r;
  assign cfg.conv_ms     = conv_r;

endmodule

// ===== hw/rtl/tspc_core.sv =====
// Poll scheduler and scratchpad CRC check: state registers and per-item result logic.
// Depends on tspc_pkg for item, result and config types and the CRC-8 step.
module tspc_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  tspc_pkg::item_t item,
  input  tspc_pkg::cfg_t  cfg,
  output tspc_pkg::res_t  res
);

  logic        conv_r,  conv_nxt;
  logic        fetch_r, fetch_nxt;
  logic [31:0] start_r, start_nxt;
  logic [31:0] next_r,  next_nxt;
  logic [3:0]  idx_r,   idx_nxt;
  logic [7:0]  crc_r,   crc_nxt;
  logic [15:0] pend_r,  pend_nxt;
  logic [15:0] raw_r,   raw_nxt;
  logic        valid_r, valid_nxt;

  logic [31:0]        start_eff;
  logic [32:0]        deadline;
  logic signed [32:0] prod;
  tspc_pkg::cmd_t     cmd;

  always_comb begin
    conv_nxt  = conv_r;
    fetch_nxt = fetch_r;
    start_nxt = start_r;
    next_nxt  = next_r;
    idx_nxt   = idx_r;
    crc_nxt   = crc_r;
    pend_nxt  = pend_r;
    raw_nxt   = raw_r;
    valid_nxt = valid_r;
    cmd       = tspc_pkg::CMD_NONE;
    // clear the start time on a clock wrap before either compare
    start_eff = (item.now_ms < start_r) ? 32'd0 : start_r;
    deadline  = {1'b0, start_eff} + {17'd0, cfg.conv_ms};

    case (item.op)
      tspc_pkg::OP_TICK: begin
        start_nxt = start_eff;
        if (!conv_r && (item.now_ms >= next_r)) begin
          conv_nxt  = 1'b1;
          start_nxt = item.now_ms;
          cmd       = tspc_pkg::CMD_CONVERT;
        end else if (conv_r && ({1'b0, item.now_ms} >= deadline)) begin
          conv_nxt  = 1'b0;
          next_nxt  = item.now_ms + {16'd0, cfg.refresh_ivl};
          fetch_nxt = 1'b1;
          idx_nxt   = 4'd0;
          crc_nxt   = 8'd0;
          pend_nxt  = 16'd0;
          cmd       = tspc_pkg::CMD_READ;
        end
      end
      tspc_pkg::OP_BYTE: begin
        if (fetch_r) begin
          if (idx_r < tspc_pkg::CRC_BYTES) begin
            crc_nxt = tspc_pkg::crc8_step(crc_r, item.data_byte);
            if (idx_r == 4'd0) begin
              pend_nxt[7:0] = item.data_byte;
            end else if (idx_r == 4'd1) begin
              pend_nxt[15:8] = item.data_byte;
            end
            idx_nxt = idx_r + 4'd1;
          end else begin
            if (crc_r == item.data_byte) begin
              raw_nxt   = pend_r;
              valid_nxt = 1'b1;
            end else begin
              valid_nxt = 1'b0;
            end
            fetch_nxt = 1'b0;
            idx_nxt   = 4'd0;
          end
        end
      end
      tspc_pkg::OP_NOPRES: begin
        if (fetch_r) begin
          fetch_nxt = 1'b0;
          idx_nxt   = 4'd0;
          valid_nxt = 1'b0;
        end
      end
      default: ;
    endcase

    prod = $signed(raw_nxt) * $signed(tspc_pkg::SCALE_UC);

    res.bus_command   = cmd;
    res.busy_res      = conv_nxt;
    res.reading_valid = valid_nxt;
    res.temp_micro_c  = valid_nxt ? prod[31:0] : 32'sd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conv_r  <= 1'b0;
      fetch_r <= 1'b0;
      start_r <= 32'd0;
      next_r  <= 32'd0;
      idx_r   <= 4'd0;
      crc_r   <= 8'd0;
      pend_r  <= 16'd0;
      raw_r   <= 16'd0;
      valid_r <= 1'b0;
    end else if (adv) begin
      conv_r  <= conv_nxt;
      fetch_r <= fetch_nxt;
      start_r <= start_nxt;
      next_r  <= next_nxt;
      idx_r   <= idx_nxt;
      crc_r   <= crc_nxt;
      pend_r  <= pend_nxt;
      raw_r   <= raw_nxt;
      valid_r <= valid_nxt;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= tspc_pkg::CRC_BYTES)
    else $error("byte index past the CRC byte");

  a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !fetch_r |-> (idx_r == 4'd0))
    else $error("byte index nonzero outside a fetch");

  a_convert_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && res.bus_command == tspc_pkg::CMD_CONVERT) |=> conv_r && !$past(conv_r))
    else $error("start command without a new conversion");

  a_read_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && res.bus_command == tspc_pkg::CMD_READ) |=> fetch_r && !conv_r && idx_r == 4'd0)
    else $error("read command without a fresh fetch");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !res.reading_valid |-> (res.temp_micro_c == 32'sd0))
    else $error("temperature nonzero on an invalid reading");

endmodule

// ===== sim/tb_temp_sensor_poll_crc8_check.sv =====
// Self-checking testbench for the temperature sensor poll scheduler with scratchpad CRC-8 check.
// Depends on tspc_pkg and the RTL top temp_sensor_poll_crc8_check; drives a directed table
// and then random poll cycles against an in-bench model of the scheduler.
module tb_temp_sensor_poll_crc8_check;
  timeunit 1ns;
  timeprecision 1ps;

  // Opcode 3 has no member in op_t; the block must ignore it.
  localparam logic [1:0]         OP_RSVD     = 2'd3;
  localparam int                 UC_PER_LSB  = 62500;
  localparam int                 PHASES      = 6;
  localparam int                 PHASE_ITEMS = 184;
  localparam int                 HOLD_CYCLES = 400;
  // Most negative reading (0x8000) in micro-degrees.
  localparam logic signed [31:0] MOST_NEG_UC = -32'sd2048000000;

  typedef struct {
    tspc_pkg::cmd_t     cmd;
    logic               busy;
    logic               valid;
    logic signed [31:0] temp;
  } poll_res_t;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] now;
    logic [7:0]  data;
    bit          data_is_crc;  // drive the running CRC as the byte
    bit          typed;        // expectation written out in the row
    poll_res_t   exp;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // [31:0] now_ms, [39:32] data_byte
  logic [1:0]  in_tuser;   // [1:0] opcode
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // [1:0] bus_command, [2] busy_res, [3] reading_valid,
                           // [35:4] temp_micro_c, [39:36] zero
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  temp_sensor_poll_crc8_check dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // ---------------------------------------------------------------------------
  // Scheduler model: register copies and poll state, updated once per accepted
  // item in acceptance order.
  // ---------------------------------------------------------------------------
  logic [15:0] refresh_ivl;
  logic [15:0] conv_ms;
  logic        conv_active;
  logic        fetch_active;
  logic [31:0] t_start;
  logic [31:0] t_next;
  logic [3:0]  scratch_idx;
  logic [7:0]  crc_acc;
  logic [15:0] raw_pend;
  logic [15:0] raw_last;
  logic        reading_good;

  poll_res_t   pending_results[$];
  dir_row_t    dir_rows[$];

  int          errors;
  int          n_items;
  int          n_directed;
  int          n_checked;
  int          n_good_fetch;
  int          n_bad_fetch;
  int          n_aborts;
  int          n_settings;
  bit          hold_req;

  // Dallas CRC-8, one data bit at a time, LSB first.
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) begin
        c = c ^ 8'h8C;
      end
    end
    return c;
  endfunction

  function automatic poll_res_t status_now(input tspc_pkg::cmd_t cmd);
    poll_res_t r;
    int        s;
    s       = int'($signed(raw_last));
    r.cmd   = cmd;
    r.busy  = conv_active;
    r.valid = reading_good;
    r.temp  = reading_good ? s * UC_PER_LSB : 0;
    return r;
  endfunction

  task automatic poll_predict(input logic [1:0] op, input logic [31:0] now,
                              input logic [7:0] data, output poll_res_t r);
    tspc_pkg::cmd_t cmd;
    cmd = tspc_pkg::CMD_NONE;
    case (op)
      tspc_pkg::OP_TICK: begin
        // Clock wrap: a time below the start clears the start.
        if (now < t_start) begin
          t_start = '0;
        end
        if (!conv_active && now >= t_next) begin
          conv_active = 1'b1;
          t_start     = now;
          cmd         = tspc_pkg::CMD_CONVERT;
        end else if (conv_active &&
                     {1'b0, now} >= {1'b0, t_start} + {17'd0, conv_ms}) begin
          // Deadline compare is 33 bits wide; next start wraps at 32.
          conv_active  = 1'b0;
          t_next       = now + {16'd0, refresh_ivl};
          fetch_active = 1'b1;
          scratch_idx  = '0;
          crc_acc      = '0;
          raw_pend     = '0;
          cmd          = tspc_pkg::CMD_READ;
        end
      end
      tspc_pkg::OP_BYTE: begin
        if (fetch_active) begin
          if (scratch_idx < 4'd8) begin
            crc_acc = crc8_next(crc_acc, data);
            if (scratch_idx == 4'd0) begin
              raw_pend[7:0] = data;
            end else if (scratch_idx == 4'd1) begin
              raw_pend[15:8] = data;
            end
            scratch_idx = scratch_idx + 4'd1;
          end else begin
            if (crc_acc == data) begin
              raw_last     = raw_pend;
              reading_good = 1'b1;
              n_good_fetch++;
            end else begin
              reading_good = 1'b0;
              n_bad_fetch++;
            end
            fetch_active = 1'b0;
            scratch_idx  = '0;
          end
        end
      end
      tspc_pkg::OP_NOPRES: begin
        if (fetch_active) begin
          fetch_active = 1'b0;
          scratch_idx  = '0;
          reading_good = 1'b0;
          n_aborts++;
        end
      end
      default: ;
    endcase
    r = status_now(cmd);
  endtask

  // Items that leave the scheduler untouched.
  function automatic bit is_ignored(input logic [1:0] op);
    return (op == OP_RSVD) || (op == tspc_pkg::OP_BYTE && !fetch_active) ||
           (op == tspc_pkg::OP_NOPRES && !fetch_active);
  endfunction

  // ---------------------------------------------------------------------------
  // Clock and timeout
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(20_000_000);
    $display("Timeout with %0d results still pending", pending_results.size());
    $display("FAIL temp_sensor_poll_crc8_check");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, plus one long hold-off on request so the
  // block fills and stalls its input.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned r;
    int          len;
    out_tready = 1'b0;
    forever begin
      if (hold_req) begin
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          len = $urandom_range(1, 40);
          repeat (len) begin
            @(negedge clk);
            out_tready <= 1'b1;
          end
        end else begin
          len = (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 60);
          repeat (len) begin
            @(negedge clk);
            out_tready <= 1'b0;
          end
        end
      end
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    poll_res_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result 0x%010h with no pending expectation", out_tdata);
        errors++;
      end else begin
        e = pending_results.pop_front();
        n_checked++;
        if (out_tdata[1:0] !== e.cmd) begin
          $error("bus_command: expected %0d, got %0d", e.cmd, out_tdata[1:0]);
          errors++;
        end
        if (out_tdata[2] !== e.busy) begin
          $error("busy_res: expected %0d, got %0d", e.busy, out_tdata[2]);
          errors++;
        end
        if (out_tdata[3] !== e.valid) begin
          $error("reading_valid: expected %0d, got %0d", e.valid, out_tdata[3]);
          errors++;
        end
        if (out_tdata[35:4] !== e.temp) begin
          $error("temp_micro_c: expected %0d, got %0d", e.temp, $signed(out_tdata[35:4]));
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side helpers
  // ---------------------------------------------------------------------------

  // Mostly back-to-back, sometimes a short gap, rarely a long one.
  function automatic int pick_gap(input bit steady);
    int unsigned r;
    if (steady) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end else if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Offer one item after an optional gap; hold it until accepted, then predict.
  // Valid stays high between back-to-back items.
  task automatic push_item(input logic [1:0] op, input logic [31:0] now,
                           input logic [7:0] data, input int gap, output poll_res_t r);
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {data, now};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    poll_predict(op, now, data, r);
    n_items++;
  endtask

  // Drop valid and wait for every outstanding result.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input tspc_pkg::reg_idx_t idx, input logic [15:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {16'd0, value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    // Read the register straight back.
    @(negedge clk);
    cfg_psel  <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata[15:0] !== value) begin
      $error("register %0d readback: expected %0d, got %0d", idx, value, cfg_prdata[15:0]);
      errors++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  function automatic void add_row(input logic [1:0] op, input logic [31:0] now,
                                  input logic [7:0] data, input bit data_is_crc,
                                  input bit typed, input tspc_pkg::cmd_t cmd,
                                  input logic busy, input logic valid,
                                  input logic signed [31:0] temp);
    dir_row_t row;
    row.op          = op;
    row.now         = now;
    row.data        = data;
    row.data_is_crc = data_is_crc;
    row.typed       = typed;
    row.exp.cmd     = cmd;
    row.exp.busy    = busy;
    row.exp.valid   = valid;
    row.exp.temp    = temp;
    dir_rows.push_back(row);
  endfunction

  // Temperature bytes lean toward the sign and range extremes.
  function automatic logic [7:0] pick_raw_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h7F;
      3:       return 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  // Build the next random item from the model's current state: mostly
  // well-formed poll cycles, with ticks aimed at the next deadline, a fetch
  // that mostly carries a good CRC, and a thin layer of noise.
  task automatic make_item(output logic [1:0] op, output logic [31:0] now,
                           output logic [7:0] data);
    int unsigned r;
    int unsigned s;
    int unsigned back;
    logic [32:0] target;
    r    = $urandom_range(0, 99);
    op   = tspc_pkg::OP_TICK;
    now  = $urandom;
    data = 8'($urandom);
    if (r < 2) begin
      op = OP_RSVD;
    end else if (r < 4) begin
      op = tspc_pkg::OP_TICK;  // random clock value, often a wrap
    end else if (r < 6) begin
      op = tspc_pkg::OP_NOPRES;
    end else if ((fetch_active && r < 90) || (!fetch_active && r < 9)) begin
      op = tspc_pkg::OP_BYTE;
      if (fetch_active) begin
        if (scratch_idx < 4'd2) begin
          data = pick_raw_byte();
        end else if (scratch_idx == 4'd8) begin
          // Mostly the right CRC; otherwise flip one bit of it.
          data = ($urandom_range(0, 99) < 85) ? crc_acc
                                              : crc_acc ^ (8'd1 << $urandom_range(0, 7));
        end
      end
    end else begin
      op     = tspc_pkg::OP_TICK;
      target = conv_active ? {1'b0, t_start} + {17'd0, conv_ms} : {1'b0, t_next};
      if (!target[32]) begin
        s = $urandom_range(0, 9);
        if (s < 5) begin
          now = target[31:0];
        end else if (s < 7) begin
          now = target[31:0] + $urandom_range(0, 50);
        end else begin
          back = $urandom_range(1, 2000);
          now  = (target >= back) ? target[31:0] - back : 32'd0;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    poll_res_t   r;
    logic [1:0]  op;
    logic [31:0] now;
    logic [7:0]  data;
    int          eff;
    bit          steady;
    logic [15:0] refresh_set[PHASES];
    logic [15:0] conv_set[PHASES];

    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    hold_req    = 1'b0;
    errors      = 0;
    n_items     = 0;
    n_directed  = 0;
    n_checked   = 0;
    n_good_fetch = 0;
    n_bad_fetch = 0;
    n_aborts    = 0;
    n_settings  = 0;

    // Model state after reset.
    refresh_ivl  = tspc_pkg::REFRESH_RESET;
    conv_ms      = tspc_pkg::CONV_RESET;
    conv_active  = 1'b0;
    fetch_active = 1'b0;
    t_start      = '0;
    t_next       = '0;
    scratch_idx  = '0;
    crc_acc      = '0;
    raw_pend     = '0;
    raw_last     = '0;
    reading_good = 1'b0;

    // Directed table, reset register values (refresh 5000, conversion 1000).
    // First tick at time zero starts a conversion; the read comes at 1000.
    add_row(tspc_pkg::OP_TICK, 32'd0,    8'h00, 0, 1, tspc_pkg::CMD_CONVERT, 1, 0, 0);
    add_row(tspc_pkg::OP_TICK, 32'd999,  8'h00, 0, 1, tspc_pkg::CMD_NONE,    1, 0, 0);
    add_row(tspc_pkg::OP_TICK, 32'd1000, 8'h00, 0, 1, tspc_pkg::CMD_READ,    0, 0, 0);
    // Scratchpad holding the most negative reading, 0x8000.
    add_row(tspc_pkg::OP_BYTE, 32'd0, 8'h00, 0, 0, tspc_pkg::CMD_NONE, 0, 0, 0);
    add_row(tspc_pkg::OP_BYTE, 32'd0, 8'h80, 0, 0, tspc_pkg::CMD_NONE, 0, 0, 0);
    add_row(tspc_pkg::OP_BYTE, 32'd0, 8'hFF, 0, 0, tspc_pkg::CMD_NONE, 0, 0, 0);
    add_row(tspc_pkg::OP_BYTE, 32'd0, 8'h00, 0, 0, tspc_pkg::CMD_NONE, 0, 0, 0);
    add_row(tspc_pkg::OP_BYTE, 32'd0, 8'h7F, 0, 0, tspc_pkg::CMD_NONE, 0, 0, 0);
    add_row(tspc_pkg::OP_BYTE, 32'd0, 8'hFF, 0, 0, tspc_pkg::CMD_NONE, 0, 0, 0);
    add_row(tspc_pkg::OP_BYTE, 32'd0, 8'h0C, 0, 0, tspc_pkg::CMD_NONE, 0, 0, 0);
    add_row(tspc_pkg::OP_BYTE, 32'd0, 8'h10, 0, 0, tspc_pkg::CMD_NONE, 0, 0, 0);
    add_row(tspc_pkg::OP_BYTE, 32'd0, 8'h00, 1, 1, tspc_pkg::CMD_NONE, 0, 1, MOST_NEG_UC);
    // Stray byte, reserved opcode and a missing presence pulse while idle.
    add_row(tspc_pkg::OP_BYTE, 32'd0, 8'hFF, 0, 1, tspc_pkg::CMD_NONE, 0, 1, MOST_NEG_UC);
    add_row(OP_RSVD, 32'hFFFFFFFF, 8'hFF, 0, 1, tspc_pkg::CMD_NONE, 0, 1, MOST_NEG_UC);
    add_row(tspc_pkg::OP_NOPRES, 32'hFFFFFFFF, 8'h00, 0, 1, tspc_pkg::CMD_NONE, 0, 1,
            MOST_NEG_UC);
    // Start near the top of the clock: the deadline must not wrap, then the
    // clock wraps and the start is cleared.
    add_row(tspc_pkg::OP_TICK, 32'hFFFFFF00, 8'h00, 0, 1, tspc_pkg::CMD_CONVERT, 1, 1,
            MOST_NEG_UC);
    add_row(tspc_pkg::OP_TICK, 32'hFFFFFFFF, 8'h00, 0, 1, tspc_pkg::CMD_NONE, 1, 1,
            MOST_NEG_UC);
    add_row(tspc_pkg::OP_TICK, 32'd5,    8'h00, 0, 1, tspc_pkg::CMD_NONE, 1, 1, MOST_NEG_UC);
    add_row(tspc_pkg::OP_TICK, 32'd1000, 8'h00, 0, 1, tspc_pkg::CMD_READ, 0, 1, MOST_NEG_UC);
    // Missing presence pulse in the middle of a fetch aborts it.
    add_row(tspc_pkg::OP_BYTE,   32'd0, 8'h12, 0, 0, tspc_pkg::CMD_NONE, 0, 1, 0);
    add_row(tspc_pkg::OP_NOPRES, 32'd0, 8'h00, 0, 1, tspc_pkg::CMD_NONE, 0, 0, 0);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      data = dir_rows[i].data_is_crc ? crc_acc : dir_rows[i].data;
      push_item(dir_rows[i].op, dir_rows[i].now, data, pick_gap(0), r);
      pending_results.push_back(dir_rows[i].typed ? dir_rows[i].exp : r);
      n_directed++;
    end

    // Register settings per phase, extremes among them.
    refresh_set = '{16'd5000, 16'd0, 16'hFFFF, 16'd1, 16'd0,    16'($urandom)};
    conv_set    = '{16'd1000, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'($urandom)};

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      cfg_write(tspc_pkg::REG_REFRESH, refresh_set[ph]);
      cfg_write(tspc_pkg::REG_CONV, conv_set[ph]);
      refresh_ivl = refresh_set[ph];
      conv_ms     = conv_set[ph];
      n_settings++;
      // Long receiver hold-off while items keep coming.
      if (ph == 1) begin
        hold_req = 1'b1;
      end
      eff    = 0;
      steady = 1'b0;
      while (eff < PHASE_ITEMS) begin
        if (eff % 48 == 0) begin
          steady = ($urandom_range(0, 3) == 0);
        end
        // Pause the sender until everything is out.
        if (ph == 3 && eff == PHASE_ITEMS / 2) begin
          drain_results();
        end
        make_item(op, now, data);
        if (!is_ignored(op)) begin
          eff++;
        end
        push_item(op, now, data, pick_gap(steady), r);
        pending_results.push_back(r);
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      errors++;
    end

    $display("Covered %0d items (%0d from the table) and %0d checked results over %0d settings;",
             n_items, n_directed, n_checked, n_settings);
    $display("scratchpads: %0d accepted, %0d CRC rejects, %0d aborted by missing presence",
             n_good_fetch, n_bad_fetch, n_aborts);
    if (errors == 0) begin
      $display("PASS temp_sensor_poll_crc8_check");
    end else begin
      $display("FAIL temp_sensor_poll_crc8_check");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/tspc_pkg.sv
hw/rtl/tspc_cfg_regs.sv
hw/rtl/tspc_core.sv
hw/rtl/temp_sensor_poll_crc8_check.sv
sim/tb_temp_sensor_poll_crc8_check.sv
